// ----- rtl/core/point_segment_distance_unit_macros.svh -----
// assertion macros for the point to segment distance unit
`ifndef POINT_SEGMENT_DISTANCE_UNIT_MACROS_SVH
`define POINT_SEGMENT_DISTANCE_UNIT_MACROS_SVH

// same-cycle implication
`define PSD_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("psd assertion failed");

// next-cycle implication
`define PSD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("psd assertion failed");

`endif

// ----- rtl/core/psd_pkg.sv -----
// shared types and region codes for the point to segment distance unit
`default_nettype none
package psd_pkg;

   typedef logic [1:0] region_type;

   localparam region_type REGION_DEGENERATE = 2'd0;
   localparam region_type REGION_BEFORE     = 2'd1;
   localparam region_type REGION_BEYOND     = 2'd2;
   localparam region_type REGION_INTERIOR   = 2'd3;

   typedef struct packed {
      logic       valid;
      region_type region;
   } ctl_type;

endpackage
`default_nettype wire

// ----- rtl/core/psd_front.sv -----
// front end: differences, products, classification and division operands
`default_nettype none
module psd_front #(
   parameter int COORD_BITS = 24
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          adv,
   input  wire logic                          in_valid,
   input  wire logic signed [COORD_BITS-1:0]  query_x,
   input  wire logic signed [COORD_BITS-1:0]  query_y,
   input  wire logic signed [COORD_BITS-1:0]  seg_start_x,
   input  wire logic signed [COORD_BITS-1:0]  seg_start_y,
   input  wire logic signed [COORD_BITS-1:0]  seg_end_x,
   input  wire logic signed [COORD_BITS-1:0]  seg_end_y,
   output psd_pkg::ctl_type                   out_ctl,
   output logic [4*COORD_BITS+1:0]            out_num,
   output logic [2*COORD_BITS:0]              out_den
);

   localparam int N  = COORD_BITS;
   localparam int DW = N + 1;
   localparam int PW = 2 * N + 2;
   localparam int MW = 2 * N + 1;
   localparam int HW = N + 1;
   localparam int NW = 4 * N + 2;

   // stage 1: differences
   logic                 v1_ff, degen1_ff, degen1_in;
   logic signed [DW-1:0] dx_ff, dy_ff, vx_ff, vy_ff, fx_ff, fy_ff;
   logic signed [DW-1:0] dx_in, dy_in, vx_in, vy_in, fx_in, fy_in;

   assign dx_in = {query_x[N-1], query_x} - {seg_start_x[N-1], seg_start_x};
   assign dy_in = {query_y[N-1], query_y} - {seg_start_y[N-1], seg_start_y};
   assign vx_in = {seg_end_x[N-1], seg_end_x} - {seg_start_x[N-1], seg_start_x};
   assign vy_in = {seg_end_y[N-1], seg_end_y} - {seg_start_y[N-1], seg_start_y};
   assign fx_in = {query_x[N-1], query_x} - {seg_end_x[N-1], seg_end_x};
   assign fy_in = {query_y[N-1], query_y} - {seg_end_y[N-1], seg_end_y};
   assign degen1_in = (seg_end_x == seg_start_x) && (seg_end_y == seg_start_y);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dx_ff     <= dx_in;
         dy_ff     <= dy_in;
         vx_ff     <= vx_in;
         vy_ff     <= vy_in;
         fx_ff     <= fx_in;
         fy_ff     <= fy_in;
         degen1_ff <= degen1_in;
      end
   end

   // stage 2: products
   logic                 v2_ff, degen2_ff;
   logic signed [PW-1:0] p_dxvx_ff, p_dyvy_ff, p_dxvy_ff, p_dyvx_ff, p_vxvx_ff;
   logic signed [PW-1:0] p_vyvy_ff, p_dxdx_ff, p_dydy_ff, p_fxfx_ff, p_fyfy_ff;
   logic signed [PW-1:0] p_dxvx_in, p_dyvy_in, p_dxvy_in, p_dyvx_in, p_vxvx_in;
   logic signed [PW-1:0] p_vyvy_in, p_dxdx_in, p_dydy_in, p_fxfx_in, p_fyfy_in;

   assign p_dxvx_in = dx_ff * vx_ff;
   assign p_dyvy_in = dy_ff * vy_ff;
   assign p_dxvy_in = dx_ff * vy_ff;
   assign p_dyvx_in = dy_ff * vx_ff;
   assign p_vxvx_in = vx_ff * vx_ff;
   assign p_vyvy_in = vy_ff * vy_ff;
   assign p_dxdx_in = dx_ff * dx_ff;
   assign p_dydy_in = dy_ff * dy_ff;
   assign p_fxfx_in = fx_ff * fx_ff;
   assign p_fyfy_in = fy_ff * fy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_dxvx_ff <= p_dxvx_in;
         p_dyvy_ff <= p_dyvy_in;
         p_dxvy_ff <= p_dxvy_in;
         p_dyvx_ff <= p_dyvx_in;
         p_vxvx_ff <= p_vxvx_in;
         p_vyvy_ff <= p_vyvy_in;
         p_dxdx_ff <= p_dxdx_in;
         p_dydy_ff <= p_dydy_in;
         p_fxfx_ff <= p_fxfx_in;
         p_fyfy_ff <= p_fyfy_in;
         degen2_ff <= degen1_ff;
      end
   end

   // stage 3: dot, length squared, cross, endpoint distances squared
   logic                 v3_ff, degen3_ff;
   logic signed [PW-1:0] dot_ff, len2_ff, cross_ff, pds_ff, pde_ff;
   logic signed [PW-1:0] dot_in, len2_in, cross_in, pds_in, pde_in;

   assign dot_in   = p_dxvx_ff + p_dyvy_ff;
   assign len2_in  = p_vxvx_ff + p_vyvy_ff;
   assign cross_in = p_dxvy_ff - p_dyvx_ff;
   assign pds_in   = p_dxdx_ff + p_dydy_ff;
   assign pde_in   = p_fxfx_ff + p_fyfy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dot_ff    <= dot_in;
         len2_ff   <= len2_in;
         cross_ff  <= cross_in;
         pds_ff    <= pds_in;
         pde_ff    <= pde_in;
         degen3_ff <= degen2_ff;
      end
   end

   // stage 4: classify, cross magnitude
   logic                 v4_ff;
   psd_pkg::region_type  region4_ff, region4_in;
   logic [MW-1:0]        cmag4_ff, cmag4_in, pd4_ff, pd4_in, len2_4_ff;
   logic signed [PW-1:0] cross_neg;

   assign cross_neg = -cross_ff;
   assign cmag4_in  = cross_ff[PW-1] ? cross_neg[MW-1:0] : cross_ff[MW-1:0];

   always_comb begin
      priority if (degen3_ff) begin
         region4_in = psd_pkg::REGION_DEGENERATE;
      end else if (dot_ff[PW-1]) begin
         region4_in = psd_pkg::REGION_BEFORE;
      end else if (dot_ff > len2_ff) begin
         region4_in = psd_pkg::REGION_BEYOND;
      end else begin
         region4_in = psd_pkg::REGION_INTERIOR;
      end
   end

   assign pd4_in = (region4_in == psd_pkg::REGION_BEYOND) ? pde_ff[MW-1:0] : pds_ff[MW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         region4_ff <= region4_in;
         cmag4_ff   <= cmag4_in;
         pd4_ff     <= pd4_in;
         len2_4_ff  <= len2_ff[MW-1:0];
      end
   end

   // stage 5: partial products of the cross magnitude squared
   logic                v5_ff;
   psd_pkg::region_type region5_ff;
   logic [MW-1:0]       pd5_ff, len2_5_ff;
   logic [N-1:0]        c_hi;
   logic [HW-1:0]       c_lo;
   logic [2*N-1:0]      hh_ff, hh_in;
   logic [2*N:0]        hl_ff, hl_in;
   logic [2*HW-1:0]     ll_ff, ll_in;

   assign c_hi  = cmag4_ff[MW-1:HW];
   assign c_lo  = cmag4_ff[HW-1:0];
   assign hh_in = c_hi * c_hi;
   assign hl_in = c_hi * c_lo;
   assign ll_in = c_lo * c_lo;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (adv) begin
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         region5_ff <= region4_ff;
         pd5_ff     <= pd4_ff;
         len2_5_ff  <= len2_4_ff;
         hh_ff      <= hh_in;
         hl_ff      <= hl_in;
         ll_ff      <= ll_in;
      end
   end

   // stage 6: dividend and divisor
   logic                v6_ff;
   psd_pkg::region_type region6_ff;
   logic [NW-1:0]       num_ff, num_in, sq;
   logic [MW-1:0]       den_ff, den_in;
   logic                interior5;

   assign interior5 = (region5_ff == psd_pkg::REGION_INTERIOR);
   assign sq = (NW'(hh_ff) << (2 * HW)) + (NW'(hl_ff) << (HW + 1)) + NW'(ll_ff);
   assign num_in = interior5 ? sq : NW'(pd5_ff);
   assign den_in = interior5 ? len2_5_ff : {{(MW-1){1'b0}}, 1'b1};

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (adv) begin
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         region6_ff <= region5_ff;
         num_ff     <= num_in;
         den_ff     <= den_in;
      end
   end

   assign out_ctl.valid  = v6_ff;
   assign out_ctl.region = region6_ff;
   assign out_num        = num_ff;
   assign out_den        = den_ff;

endmodule
`default_nettype wire

// ----- rtl/core/psd_div.sv -----
// pipelined restoring divider, one quotient bit per stage
`default_nettype none
module psd_div #(
   parameter int COORD_BITS = 24
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       adv,
   input  wire psd_pkg::ctl_type           in_ctl,
   input  wire logic [4*COORD_BITS+1:0]    in_num,
   input  wire logic [2*COORD_BITS:0]      in_den,
   output psd_pkg::ctl_type                out_ctl,
   output logic [2*COORD_BITS:0]           out_quo
);

   localparam int N  = COORD_BITS;
   localparam int MW = 2 * N + 1;
   localparam int NW = 4 * N + 2;

   psd_pkg::ctl_type ctl_ff [1:MW];
   logic [MW-1:0]    rem_ff [1:MW];
   logic [MW-1:0]    quo_ff [1:MW];
   logic [MW-1:0]    den_ff [1:MW];

   for (genvar k = 0; k < MW; k++) begin : g_stage
      psd_pkg::ctl_type ctl_src;
      logic [MW-1:0]    rem_src, quo_src, den_src, rem_in, quo_in;
      logic [MW:0]      t;
      logic [MW+1:0]    diff;
      logic             ge;

      if (k == 0) begin : g_first
         assign ctl_src = in_ctl;
         assign rem_src = in_num[NW-1:MW];
         assign quo_src = in_num[MW-1:0];
         assign den_src = in_den;
      end else begin : g_next
         assign ctl_src = ctl_ff[k];
         assign rem_src = rem_ff[k];
         assign quo_src = quo_ff[k];
         assign den_src = den_ff[k];
      end

      assign t      = {rem_src, quo_src[MW-1]};
      assign diff   = {1'b0, t} - {2'b00, den_src};
      assign ge     = ~diff[MW+1];
      assign rem_in = ge ? diff[MW-1:0] : t[MW-1:0];
      assign quo_in = {quo_src[MW-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[k+1].valid <= 1'b0;
         end else if (adv) begin
            ctl_ff[k+1].valid <= ctl_src.valid;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            ctl_ff[k+1].region <= ctl_src.region;
            rem_ff[k+1]        <= rem_in;
            quo_ff[k+1]        <= quo_in;
            den_ff[k+1]        <= den_src;
         end
      end
   end

   assign out_ctl = ctl_ff[MW];
   assign out_quo = quo_ff[MW];

endmodule
`default_nettype wire

// ----- rtl/core/psd_sqrt.sv -----
// pipelined integer square root, one root bit per stage
`default_nettype none
module psd_sqrt #(
   parameter int COORD_BITS = 24
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  adv,
   input  wire psd_pkg::ctl_type      in_ctl,
   input  wire logic [2*COORD_BITS:0] in_rad,
   output psd_pkg::ctl_type           out_ctl,
   output logic [COORD_BITS:0]        out_root
);

   localparam int N  = COORD_BITS;
   localparam int K  = N + 1;
   localparam int RW = 2 * N + 2;
   localparam int EW = N + 2;

   psd_pkg::ctl_type ctl_ff  [1:K];
   logic [EW-1:0]    rem_ff  [1:K];
   logic [K-1:0]     root_ff [1:K];
   logic [RW-1:0]    rad_ff  [1:K];

   for (genvar k = 0; k < K; k++) begin : g_stage
      psd_pkg::ctl_type ctl_src;
      logic [EW-1:0]    rem_src, rem_in;
      logic [K-1:0]     root_src, root_in;
      logic [RW-1:0]    rad_src, rad_in;
      logic [EW+1:0]    t, trial;
      logic [EW+2:0]    diff;
      logic             ge;

      if (k == 0) begin : g_first
         assign ctl_src  = in_ctl;
         assign rem_src  = '0;
         assign root_src = '0;
         assign rad_src  = {1'b0, in_rad};
      end else begin : g_next
         assign ctl_src  = ctl_ff[k];
         assign rem_src  = rem_ff[k];
         assign root_src = root_ff[k];
         assign rad_src  = rad_ff[k];
      end

      assign t       = {rem_src, rad_src[RW-1:RW-2]};
      assign trial   = {root_src, 2'b01};
      assign diff    = {1'b0, t} - {1'b0, trial};
      assign ge      = ~diff[EW+2];
      assign rem_in  = ge ? diff[EW-1:0] : t[EW-1:0];
      assign root_in = {root_src[K-2:0], ge};
      assign rad_in  = {rad_src[RW-3:0], 2'b00};

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[k+1].valid <= 1'b0;
         end else if (adv) begin
            ctl_ff[k+1].valid <= ctl_src.valid;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            ctl_ff[k+1].region <= ctl_src.region;
            rem_ff[k+1]        <= rem_in;
            root_ff[k+1]       <= root_in;
            rad_ff[k+1]        <= rad_in;
         end
      end
   end

   assign out_ctl  = ctl_ff[K];
   assign out_root = root_ff[K];

endmodule
`default_nettype wire

// ----- rtl/core/point_segment_distance_unit.sv -----
// top level of the point to segment distance unit
//
// Takes one request per cycle while req_ready is high: a query point and a
// segment, signed fixed point. Returns the floored Euclidean distance and a
// region code (degenerate segment, before start, beyond end, interior). The
// pipeline has six front stages of differences, products and classification,
// 2*COORD_BITS+1 divider stages and COORD_BITS+1 square root stages, one
// result bit per stage. When the result is not taken the whole pipeline
// holds; nothing is dropped or repeated.
`default_nettype none
`include "point_segment_distance_unit_macros.svh"
module point_segment_distance_unit #(
   parameter int COORD_BITS = 24
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic signed [COORD_BITS-1:0]  req_query_x,
   input  wire logic signed [COORD_BITS-1:0]  req_query_y,
   input  wire logic signed [COORD_BITS-1:0]  req_seg_start_x,
   input  wire logic signed [COORD_BITS-1:0]  req_seg_start_y,
   input  wire logic signed [COORD_BITS-1:0]  req_seg_end_x,
   input  wire logic signed [COORD_BITS-1:0]  req_seg_end_y,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [COORD_BITS:0]                rsp_distance,
   output logic [1:0]                         rsp_region
);

   psd_pkg::ctl_type          front_ctl, div_ctl, sqrt_ctl;
   logic [4*COORD_BITS+1:0]   front_num;
   logic [2*COORD_BITS:0]     front_den;
   logic [2*COORD_BITS:0]     div_quo;
   logic                      adv;

   // whole pipeline moves unless the result register is full and stalled
   assign adv       = !sqrt_ctl.valid || rsp_ready;
   assign req_ready = adv;

   psd_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (req_valid),
      .query_x     (req_query_x),
      .query_y     (req_query_y),
      .seg_start_x (req_seg_start_x),
      .seg_start_y (req_seg_start_y),
      .seg_end_x   (req_seg_end_x),
      .seg_end_y   (req_seg_end_y),
      .out_ctl     (front_ctl),
      .out_num     (front_num),
      .out_den     (front_den)
   );

   psd_div #(.COORD_BITS(COORD_BITS)) u_div (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .in_ctl  (front_ctl),
      .in_num  (front_num),
      .in_den  (front_den),
      .out_ctl (div_ctl),
      .out_quo (div_quo)
   );

   psd_sqrt #(.COORD_BITS(COORD_BITS)) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_ctl   (div_ctl),
      .in_rad   (div_quo),
      .out_ctl  (sqrt_ctl),
      .out_root (rsp_distance)
   );

   assign rsp_valid  = sqrt_ctl.valid;
   assign rsp_region = sqrt_ctl.region;

   // interior requests always divide by a non-zero length squared
   `PSD_ASSERT_IMPL(a_interior_den, clock, reset, front_ctl.valid && (front_ctl.region == psd_pkg::REGION_INTERIOR), front_den != '0)
   // endpoint cases pass the squared distance through a unit divisor
   `PSD_ASSERT_IMPL(a_point_den, clock, reset, front_ctl.valid && (front_ctl.region != psd_pkg::REGION_INTERIOR), front_den == {{(2*COORD_BITS){1'b0}}, 1'b1})
   // a stall freezes the divider output
   `PSD_ASSERT_NEXT(a_stall_hold, clock, reset, !adv, $stable(div_ctl) && $stable(div_quo))

endmodule
`default_nettype wire
